/* src/shingle_simhash_fnv1a64_macros.svh */
// Assertion macros shared by the shingle SimHash RTL.
`ifndef SHINGLE_SIMHASH_FNV1A64_MACROS_SVH
`define SHINGLE_SIMHASH_FNV1A64_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define SHS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/shs_pkg.sv */
// Shared types, constants and the FNV-1a byte mix for the shingle SimHash block.
package shs_pkg;

  localparam int HASH_W  = 64;
  localparam int COUNT_W = 32;
  localparam int BYTE_W  = 8;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;
  localparam logic [BYTE_W-1:0] GAP_BYTE  = 8'h20;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Tally memory: one row holds TALLY_LANES tallies.
  localparam int TALLY_LANES = 8;
  localparam int TALLY_ROWS  = HASH_W / TALLY_LANES;
  localparam int ROW_W       = $clog2(TALLY_ROWS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GAP,
    ST_BYTE,
    ST_CLOSE,
    ST_SWEEP,
    ST_DONE
  } shs_state_t;

  typedef struct packed {
    logic              gap;
    logic              mix;
    logic              close;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } slot_cmd_t;

  typedef struct packed {
    logic              at_start;
    logic              close_hit;
    logic [HASH_W-1:0] shingle_hash;
  } slot_stat_t;

  typedef struct packed {
    logic start;
    logic add;
    logic clear;
  } tally_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tally_stat_t;

  // h ^ b, times the FNV prime 2^40 + 0x1b3, as a shift-add
  function automatic logic [HASH_W-1:0] fnv_mix(input logic [HASH_W-1:0] h,
                                                input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] x;
    x = h ^ {{(HASH_W-BYTE_W){1'b0}}, b};
    return x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
  endfunction

endpackage

/* src/shs_in_if.sv */
// Input byte stream channel: valid/ready plus token byte and marks.
interface shs_in_if;
  import shs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              byte_valid;
  logic              token_end;
  logic              text_end;

  modport source (output valid, output data_byte, output byte_valid,
                  output token_end, output text_end, input ready);
  modport sink   (input valid, input data_byte, input byte_valid,
                  input token_end, input text_end, output ready);
endinterface

/* src/shs_out_if.sv */
// Result channel: valid/ready plus fingerprint and counts.
interface shs_out_if;
  import shs_pkg::*;

  logic               valid;
  logic               ready;
  logic [HASH_W-1:0]  fingerprint;
  logic [COUNT_W-1:0] token_count;
  logic [COUNT_W-1:0] shingle_count;

  modport source (output valid, output fingerprint, output token_count,
                  output shingle_count, input ready);
  modport sink   (input valid, input fingerprint, input token_count,
                  input shingle_count, output ready);
endinterface

/* src/shs_slots.sv */
// Open shingle slots: running FNV-1a hashes, token lengths and token-start flag.
module shs_slots #(
  parameter int SHINGLE_TOKENS = 3
) (
  input  logic               clk,
  input  logic               rst_n,
  input  shs_pkg::slot_cmd_t  cmd,
  output shs_pkg::slot_stat_t stat
);
  import shs_pkg::*;

  localparam int LEN_W = $clog2(SHINGLE_TOKENS + 1);
  localparam logic [LEN_W-1:0] LAST_LEN = LEN_W'(SHINGLE_TOKENS - 1);

  logic [HASH_W-1:0]         hash_r   [SHINGLE_TOKENS];
  logic [HASH_W-1:0]         hash_nxt [SHINGLE_TOKENS];
  logic [LEN_W-1:0]          len_r    [SHINGLE_TOKENS];
  logic [LEN_W-1:0]          len_nxt  [SHINGLE_TOKENS];
  logic [SHINGLE_TOKENS-1:0] open_r;
  logic [SHINGLE_TOKENS-1:0] open_nxt;
  logic                      at_start_r;
  logic                      at_start_nxt;
  logic [SHINGLE_TOKENS-1:0] free;
  logic [SHINGLE_TOKENS-1:0] pick;
  logic [SHINGLE_TOKENS-1:0] hit;
  logic [HASH_W-1:0]         hit_hash;

  // lowest free slot, one-hot
  assign free = ~open_r;
  assign pick = free & (~free + SHINGLE_TOKENS'(1));

  always_comb begin
    open_nxt     = open_r;
    at_start_nxt = at_start_r;
    for (int j = 0; j < SHINGLE_TOKENS; j++) begin
      hash_nxt[j] = hash_r[j];
      len_nxt[j]  = len_r[j];
    end
    if (cmd.clear) begin
      open_nxt     = '0;
      at_start_nxt = 1'b1;
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        len_nxt[j] = '0;
      end
    end else if (cmd.gap) begin
      at_start_nxt = 1'b0;
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        if (open_r[j]) begin
          hash_nxt[j] = fnv_mix(hash_r[j], GAP_BYTE);
        end else if (pick[j]) begin
          open_nxt[j] = 1'b1;
          len_nxt[j]  = '0;
          hash_nxt[j] = FNV_BASIS;
        end
      end
    end else if (cmd.mix) begin
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        if (open_r[j]) begin
          hash_nxt[j] = fnv_mix(hash_r[j], cmd.data);
        end
      end
    end else if (cmd.close) begin
      at_start_nxt = 1'b1;
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        if (open_r[j]) begin
          if (len_r[j] == LAST_LEN) begin
            open_nxt[j] = 1'b0;
            len_nxt[j]  = '0;
          end else begin
            len_nxt[j] = len_r[j] + LEN_W'(1);
          end
        end
      end
    end
  end

  // at most one open slot sits one token short of a full shingle
  always_comb begin
    hit      = '0;
    hit_hash = '0;
    for (int j = 0; j < SHINGLE_TOKENS; j++) begin
      hit[j] = open_r[j] && (len_r[j] == LAST_LEN);
      if (hit[j]) begin
        hit_hash = hash_r[j];
      end
    end
    stat.at_start     = at_start_r;
    stat.close_hit    = |hit;
    // slot 0 always holds the first shingle of a text
    stat.shingle_hash = (|hit) ? hit_hash : hash_r[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= '0;
      at_start_r <= 1'b1;
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        len_r[j] <= '0;
      end
    end else begin
      open_r     <= open_nxt;
      at_start_r <= at_start_nxt;
      for (int j = 0; j < SHINGLE_TOKENS; j++) begin
        len_r[j] <= len_nxt[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < SHINGLE_TOKENS; j++) begin
      hash_r[j] <= hash_nxt[j];
    end
  end

endmodule

/* src/shs_tally.sv */
// Bit tally memory: row sweep that adds a shingle (or only reads), reads out tallies above zero.
`include "shingle_simhash_fnv1a64_macros.svh"

module shs_tally #(
  parameter int TALLY_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  shs_pkg::tally_cmd_t        cmd,
  input  logic [shs_pkg::HASH_W-1:0] shingle_hash,
  output shs_pkg::tally_stat_t       stat,
  output logic [shs_pkg::HASH_W-1:0] fingerprint
);
  import shs_pkg::*;

  localparam int DATA_W = TALLY_LANES * TALLY_WIDTH;
  localparam logic signed [TALLY_WIDTH-1:0] T_MAX = {1'b0, {(TALLY_WIDTH-1){1'b1}}};
  localparam logic signed [TALLY_WIDTH-1:0] T_MIN = {1'b1, {(TALLY_WIDTH-1){1'b0}}};
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(TALLY_ROWS - 1);

  logic [DATA_W-1:0]      mem [TALLY_ROWS];
  logic [TALLY_ROWS-1:0]  row_valid_r;

  logic                   rd_active_r;
  logic [ROW_W-1:0]       rd_row_r;
  logic                   wb_vld_r;
  logic [ROW_W-1:0]       wb_row_r;
  logic                   wb_ok_r;
  logic [DATA_W-1:0]      rd_data_r;
  logic                   add_r;
  logic [HASH_W-1:0]      hash_r;
  logic [HASH_W-1:0]      fp_r;

  logic [TALLY_LANES-1:0]        row_bits;
  logic signed [TALLY_WIDTH-1:0] old_lane [TALLY_LANES];
  logic signed [TALLY_WIDTH-1:0] new_lane [TALLY_LANES];
  logic [TALLY_LANES-1:0]        wb_bits;
  logic [DATA_W-1:0]             wb_data;

  assign row_bits = hash_r[wb_row_r*TALLY_LANES +: TALLY_LANES];

  // saturating +1/-1 per lane; rows never written since clear read as zero
  always_comb begin
    for (int k = 0; k < TALLY_LANES; k++) begin
      old_lane[k] = wb_ok_r ? rd_data_r[k*TALLY_WIDTH +: TALLY_WIDTH] : '0;
      if (!add_r) begin
        new_lane[k] = old_lane[k];
      end else if (row_bits[k]) begin
        new_lane[k] = (old_lane[k] == T_MAX) ? old_lane[k]
                                             : old_lane[k] + TALLY_WIDTH'(1);
      end else begin
        new_lane[k] = (old_lane[k] == T_MIN) ? old_lane[k]
                                             : old_lane[k] - TALLY_WIDTH'(1);
      end
      wb_bits[k] = !new_lane[k][TALLY_WIDTH-1] && (new_lane[k] != '0);
      wb_data[k*TALLY_WIDTH +: TALLY_WIDTH] = new_lane[k];
    end
  end

  assign stat.busy   = rd_active_r || wb_vld_r;
  assign stat.done   = wb_vld_r && (wb_row_r == LAST_ROW);
  assign fingerprint = fp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_active_r <= 1'b0;
      rd_row_r    <= '0;
      wb_vld_r    <= 1'b0;
      row_valid_r <= '0;
    end else begin
      if (cmd.start) begin
        rd_active_r <= 1'b1;
        rd_row_r    <= '0;
      end else if (rd_active_r) begin
        rd_row_r <= rd_row_r + ROW_W'(1);
        if (rd_row_r == LAST_ROW) begin
          rd_active_r <= 1'b0;
        end
      end
      wb_vld_r <= rd_active_r;
      if (cmd.clear) begin
        row_valid_r <= '0;
      end else if (wb_vld_r && add_r) begin
        row_valid_r[wb_row_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      add_r  <= cmd.add;
      hash_r <= shingle_hash;
    end
    if (rd_active_r) begin
      wb_row_r <= rd_row_r;
      wb_ok_r  <= row_valid_r[rd_row_r];
    end
    if (wb_vld_r) begin
      fp_r[wb_row_r*TALLY_LANES +: TALLY_LANES] <= wb_bits;
    end
  end

  // memory: one read port, one write port, registered read data
  always_ff @(posedge clk) begin
    if (rd_active_r) begin
      rd_data_r <= mem[rd_row_r];
    end
  end

  always_ff @(posedge clk) begin
    if (wb_vld_r && add_r) begin
      mem[wb_row_r] <= wb_data;
    end
  end

  `SHS_ASSERT_NOW(a_start_when_idle, clk, rst_n, cmd.start, !stat.busy, "tally sweep started while busy")
  `SHS_ASSERT_NOW(a_no_row_overlap, clk, rst_n, wb_vld_r && rd_active_r, wb_row_r != rd_row_r, "tally read and write hit the same row")
  `SHS_ASSERT_NEXT(a_idle_after_done, clk, rst_n, stat.done, !stat.busy, "tally still busy after last row")

endmodule

/* src/shs_ctrl.sv */
// Item sequencer: step FSM, token/shingle counts and the result register.
`include "shingle_simhash_fnv1a64_macros.svh"

module shs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  shs_in_if.sink                     in_ch,
  shs_out_if.source                  out_ch,
  input  shs_pkg::slot_stat_t        slot_stat,
  output shs_pkg::slot_cmd_t         slot_cmd,
  input  shs_pkg::tally_stat_t       tally_stat,
  input  logic [shs_pkg::HASH_W-1:0] tally_fp,
  output shs_pkg::tally_cmd_t        tally_cmd
);
  import shs_pkg::*;

  shs_state_t         state_r;
  shs_state_t         state_nxt;

  logic [BYTE_W-1:0]  byte_r;
  logic               bvalid_r;
  logic               tend_r;
  logic               xend_r;

  logic [COUNT_W-1:0] tok_r;
  logic [COUNT_W-1:0] tok_nxt;
  logic [COUNT_W-1:0] shg_r;
  logic [COUNT_W-1:0] shg_nxt;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic [HASH_W-1:0]  fp_out_r;
  logic [COUNT_W-1:0] tok_out_r;
  logic [COUNT_W-1:0] shg_out_r;

  logic               in_accept;
  logic               out_free;
  logic               load_out;
  logic               close_cond;
  logic               hit;
  logic               fallback;
  logic               add_now;

  // finishing decisions, valid in ST_CLOSE
  always_comb begin
    close_cond = bvalid_r ? (tend_r || xend_r) : (xend_r && !slot_stat.at_start);
    hit        = close_cond && slot_stat.close_hit;
    fallback   = xend_r && !hit && (shg_r == '0) && ((tok_r != '0) || close_cond);
    add_now    = hit || fallback;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = (in_ch.byte_valid && slot_stat.at_start) ? ST_GAP : ST_BYTE;
        end
      end
      ST_GAP:   state_nxt = ST_BYTE;
      ST_BYTE:  state_nxt = ST_CLOSE;
      ST_CLOSE: state_nxt = (add_now || xend_r) ? ST_SWEEP : ST_IDLE;
      ST_SWEEP: begin
        if (tally_stat.done) begin
          state_nxt = xend_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready     = (state_r == ST_IDLE);
    in_accept       = in_ch.valid && (state_r == ST_IDLE);
    out_free        = !out_valid_r || out_ch.ready;
    load_out        = (state_r == ST_DONE) && out_free;

    slot_cmd.gap    = (state_r == ST_GAP);
    slot_cmd.mix    = (state_r == ST_BYTE) && bvalid_r;
    slot_cmd.close  = (state_r == ST_CLOSE) && close_cond;
    slot_cmd.clear  = load_out;
    slot_cmd.data   = byte_r;

    tally_cmd.start = (state_r == ST_CLOSE) && (add_now || xend_r);
    tally_cmd.add   = add_now;
    tally_cmd.clear = load_out;

    tok_nxt = tok_r;
    shg_nxt = shg_r;
    if (load_out) begin
      tok_nxt = '0;
      shg_nxt = '0;
    end else if (state_r == ST_CLOSE) begin
      if (close_cond && (tok_r != COUNT_MAX)) begin
        tok_nxt = tok_r + COUNT_W'(1);
      end
      if (add_now && (shg_r != COUNT_MAX)) begin
        shg_nxt = shg_r + COUNT_W'(1);
      end
    end

    out_valid_nxt = load_out || (out_valid_r && !out_ch.ready);
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fingerprint   = fp_out_r;
  assign out_ch.token_count   = tok_out_r;
  assign out_ch.shingle_count = shg_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tok_r       <= '0;
      shg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tok_r       <= tok_nxt;
      shg_r       <= shg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r   <= in_ch.data_byte;
      bvalid_r <= in_ch.byte_valid;
      tend_r   <= in_ch.token_end;
      xend_r   <= in_ch.text_end;
    end
    if (load_out) begin
      fp_out_r  <= tally_fp;
      tok_out_r <= tok_r;
      shg_out_r <= shg_r;
    end
  end

  `SHS_ASSERT_NOW(a_shingles_le_tokens, clk, rst_n, 1'b1, shg_r <= tok_r, "more shingles than tokens")
  `SHS_ASSERT_NOW(a_sweep_running, clk, rst_n, state_r == ST_SWEEP, tally_stat.busy, "waiting on an idle tally sweep")
  `SHS_ASSERT_NEXT(a_result_clears, clk, rst_n, load_out, out_ch.valid && (tok_r == '0) && (shg_r == '0) && slot_stat.at_start, "state not cleared with result")

endmodule

/* src/shingle_simhash_fnv1a64.sv */
// Top level of the streaming 3-token shingle SimHash over FNV-1a 64.
//
// Takes the bytes of ready-made tokens, one byte per transfer on in_ch, with
// byte_valid, token_end and text_end marks. Every token opens a shingle slot;
// each open slot keeps a running FNV-1a 64 hash with a space byte hashed
// between tokens. When a slot has SHINGLE_TOKENS tokens it is finished and
// its hash moves 64 signed, saturating tallies (+1 for a one bit, -1 for a
// zero bit). text_end closes an unfinished token; a text too short for a
// full shingle counts all its tokens as one shingle. text_end then yields
// one transfer on out_ch (fingerprint = tallies above zero, token and
// shingle counts, both saturating at 2^32-1) and clears all state. Items
// without text_end give no result.
//
// Steps: an item goes through accept, byte mix and token close, with a gap
// step first when it is the first byte of a token (the space byte is mixed
// there). The tallies live in one memory of 8 rows by 8 tallies; any item
// that finishes a shingle, and every text_end item, adds one sweep through
// it: one row read per cycle, each row written back from the registered
// read data. text_end then waits to load the result register while
// the previous result has not been taken. The next item is accepted while
// a result waits on out_ch.
//
// Reset: synchronous, active low. Tally rows carry valid bits cleared by
// reset and at each result, so no clearing pass is needed.
module shingle_simhash_fnv1a64 #(
  parameter int SHINGLE_TOKENS = 3,   // tokens per shingle, 1 to 8
  parameter int TALLY_WIDTH    = 32   // signed tally width, 8 to 48
) (
  input  logic      clk,
  input  logic      rst_n,
  shs_in_if.sink    in_ch,
  shs_out_if.source out_ch
);
  import shs_pkg::*;

  slot_cmd_t         slot_cmd;
  slot_stat_t        slot_stat;
  tally_cmd_t        tally_cmd;
  tally_stat_t       tally_stat;
  logic [HASH_W-1:0] tally_fp;

  // step sequencer, counts and result register
  shs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .slot_stat  (slot_stat),
    .slot_cmd   (slot_cmd),
    .tally_stat (tally_stat),
    .tally_fp   (tally_fp),
    .tally_cmd  (tally_cmd)
  );

  // open shingle hashes, one FNV mix unit per slot
  shs_slots #(
    .SHINGLE_TOKENS (SHINGLE_TOKENS)
  ) u_slots (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (slot_cmd),
    .stat  (slot_stat)
  );

  // tally memory with read-modify-write row sweep
  shs_tally #(
    .TALLY_WIDTH (TALLY_WIDTH)
  ) u_tally (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (tally_cmd),
    .shingle_hash (slot_stat.shingle_hash),
    .stat         (tally_stat),
    .fingerprint  (tally_fp)
  );

endmodule
